FILE: rtl/core/assert_macros.svh
// assertion helper macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/lecg_pkg.sv
// shared types and register indexes of the led effect color generator
// no dependencies
package lecg_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH_BLUE  = 3'd5;

    localparam logic [31:0] PERIOD_RESET = 32'd1000;
    localparam logic [10:0] COUNT_RESET  = 11'd1;

    typedef struct packed {
        logic        effect_mode;
        logic [31:0] period;
        logic [10:0] led_count;
        logic [7:0]  breath_red;
        logic [7:0]  breath_green;
        logic [7:0]  breath_blue;
    } t_cfg;

endpackage

FILE: rtl/core/lecg_front.sv
// front end: accepts requests, checks the index and runs the phase and
// offset dividers as a bit-per-stage pipeline; uses lecg_pkg
module lecg_front #(
    parameter int PHASE_BITS = 16,
    parameter int LED_CAP    = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lecg_pkg::t_cfg          i_cfg,
    input  logic                    i_take,
    input  logic [31:0]             i_elapsed_ms,
    input  logic [9:0]              i_led_index,
    output logic                    o_push,
    output logic [2*PHASE_BITS:0]   o_item
);
    localparam int PB = PHASE_BITS;
    localparam int L  = 32 + PB;

    logic          r_vld  [L];
    logic [31:0]   r_el   [L];
    logic [31:0]   r_rem  [L];
    logic [10:0]   r_orem [L];
    logic [PB-1:0] r_oq   [L];
    logic [PB-1:0] r_pq   [L];
    logic          r_ok   [L];

    logic          n_vld  [L];
    logic [31:0]   n_el   [L];
    logic [31:0]   n_rem  [L];
    logic [10:0]   n_orem [L];
    logic [PB-1:0] n_oq   [L];
    logic [PB-1:0] n_pq   [L];
    logic          n_ok   [L];

    logic [10:0] cnt;
    assign cnt = ({21'b0, i_cfg.led_count} > 32'(LED_CAP)) ? 11'(LED_CAP)
                                                           : i_cfg.led_count;

    always_comb begin
        logic [32:0] t;
        logic [11:0] to;
        logic        v;
        logic [31:0] e;
        logic [31:0] rm;
        logic [10:0] orm;
        logic [PB-1:0] oq;
        logic [PB-1:0] pq;
        logic        ok;
        for (int j = 0; j < L; j++) begin
            if (j == 0) begin
                v   = i_take;
                e   = i_elapsed_ms;
                rm  = '0;
                orm = {1'b0, i_led_index};
                oq  = '0;
                pq  = '0;
                ok  = ({1'b0, i_led_index} < cnt);
            end else begin
                v   = r_vld[j-1];
                e   = r_el[j-1];
                rm  = r_rem[j-1];
                orm = r_orem[j-1];
                oq  = r_oq[j-1];
                pq  = r_pq[j-1];
                ok  = r_ok[j-1];
            end
            if (j < 32) begin
                t = {rm, e[31]};
                e = {e[30:0], 1'b0};
                if (t >= {1'b0, i_cfg.period}) begin
                    t = t - {1'b0, i_cfg.period};
                end
                rm = t[31:0];
            end else begin
                t = {rm, 1'b0};
                if (t >= {1'b0, i_cfg.period}) begin
                    t  = t - {1'b0, i_cfg.period};
                    pq = {pq[PB-2:0], 1'b1};
                end else begin
                    pq = {pq[PB-2:0], 1'b0};
                end
                rm = t[31:0];
            end
            if (j < PB) begin
                to = {orm, 1'b0};
                if (to >= {1'b0, cnt}) begin
                    to = to - {1'b0, cnt};
                    oq = {oq[PB-2:0], 1'b1};
                end else begin
                    oq = {oq[PB-2:0], 1'b0};
                end
                orm = to[10:0];
            end
            n_vld[j]  = v;
            n_el[j]   = e;
            n_rem[j]  = rm;
            n_orem[j] = orm;
            n_oq[j]   = oq;
            n_pq[j]   = pq;
            n_ok[j]   = ok;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < L; j++) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= n_vld[j];
            end
            r_el[j]   <= n_el[j];
            r_rem[j]  <= n_rem[j];
            r_orem[j] <= n_orem[j];
            r_oq[j]   <= n_oq[j];
            r_pq[j]   <= n_pq[j];
            r_ok[j]   <= n_ok[j];
        end
    end

    logic [PB-1:0] phase;
    assign phase  = (i_cfg.period == 32'd0) ? '0 : r_pq[L-1];
    assign o_push = r_vld[L-1];
    assign o_item = {r_ok[L-1], phase, r_oq[L-1]};
endmodule

FILE: rtl/core/lecg_queue.sv
// two-entry queue between the front end and the color back end
// uses assert_macros.svh
`include "assert_macros.svh"
module lecg_queue #(
    parameter int W = 33
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_empty,
    output logic         o_full,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    logic do_pop;
    assign do_pop  = i_pop && !o_empty;
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, do_pop};
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !do_pop)
    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt == 2'd3)
    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && o_empty, !o_empty)
endmodule

FILE: rtl/core/lecg_back.sv
// back end: rainbow segment ramps and breathing wave lookup and scaling
// uses lecg_pkg
module lecg_back #(
    parameter int PHASE_BITS       = 16,
    parameter int WAVE_TABLE_DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lecg_pkg::t_cfg        i_cfg,
    input  logic                  i_vld,
    input  logic [2*PHASE_BITS:0] i_item,
    output logic                  o_valid,
    output logic [7:0]            o_red_level,
    output logic [7:0]            o_green_level,
    output logic [7:0]            o_blue_level,
    output logic                  o_index_valid
);
    localparam int PB = PHASE_BITS;
    localparam int KW = $clog2(WAVE_TABLE_DEPTH);
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef logic [16:0] t_wave [WAVE_TABLE_DEPTH];

    function automatic logic [63:0] sin_q30(input logic [63:0] theta);
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] sum;
        th2  = (theta * theta) >> 30;
        term = theta;
        sum  = theta;
        for (int n = 1; n <= 6; n++) begin
            term = (term * th2) >> 30;
            case (n)
                1: term = term / 6;
                2: term = term / 20;
                3: term = term / 42;
                4: term = term / 72;
                5: term = term / 110;
                default: term = term / 156;
            endcase
            if (n % 2 == 1) begin
                sum = (term > sum) ? 64'd0 : sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return (sum > ONE_Q30) ? ONE_Q30 : sum;
    endfunction

    function automatic t_wave build_wave();
        t_wave       w;
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] q;
        for (int k = 0; k < WAVE_TABLE_DEPTH; k++) begin
            u = (2 * k <= WAVE_TABLE_DEPTH) ? 64'(k) : 64'(WAVE_TABLE_DEPTH - k);
            s = sin_q30((PI_Q30 * u) / WAVE_TABLE_DEPTH);
            q = (s * s + (64'd1 << 43)) >> 44;
            w[k] = q[16:0];
        end
        return w;
    endfunction

    localparam t_wave WAVE = build_wave();

    logic [PB-1:0] in_off;
    logic [PB-1:0] in_phase;
    logic          in_ok;
    assign in_off   = i_item[PB-1:0];
    assign in_phase = i_item[2*PB-1:PB];
    assign in_ok    = i_item[2*PB];

    // stage 1: segment split and table address
    logic [PB-1:0]    lp;
    logic [PB+2:0]    six;
    logic [PB+KW:0]   kprod;
    logic [KW:0]      kfull;
    logic [KW-1:0]    n_k;
    assign lp    = in_phase + in_off;
    assign six   = {3'b0, lp} * (PB+3)'(6);
    assign kprod = {{(KW+1){1'b0}}, in_phase} * (PB+KW+1)'(WAVE_TABLE_DEPTH);
    assign kfull = kprod[PB+KW:PB];
    assign n_k   = ({{(31-KW){1'b0}}, kfull} >= 32'(WAVE_TABLE_DEPTH))
                   ? KW'(WAVE_TABLE_DEPTH - 1) : kfull[KW-1:0];

    logic          r1_vld;
    logic          r1_ok;
    logic [2:0]    r1_seg;
    logic [PB-1:0] r1_f;
    logic [KW-1:0] r1_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_ok  <= in_ok;
        r1_seg <= six[PB+2:PB];
        r1_f   <= six[PB-1:0];
        r1_k   <= n_k;
    end

    // stage 2: wave read and rainbow ramps
    logic [PB:0]   fi;
    logic [PB+7:0] up255;
    logic [PB+8:0] dn255;
    logic [PB+7:0] up128;
    logic [PB+7:0] up127;
    logic [7:0]    a_up255;
    logic [7:0]    a_dn255;
    logic [7:0]    a_up128;
    logic [7:0]    a_up127;
    assign fi      = (PB+1)'(1) << PB;
    assign up255   = {8'b0, r1_f} * (PB+8)'(255);
    assign dn255   = {8'b0, fi - {1'b0, r1_f}} * (PB+9)'(255);
    assign up128   = {8'b0, r1_f} * (PB+8)'(128);
    assign up127   = {8'b0, r1_f} * (PB+8)'(127);
    assign a_up255 = up255[PB+7:PB];
    assign a_dn255 = dn255[PB+7:PB];
    assign a_up128 = up128[PB+7:PB];
    assign a_up127 = up127[PB+7:PB];

    logic [7:0] n_rr;
    logic [7:0] n_rg;
    logic [7:0] n_rb;
    always_comb begin
        case (r1_seg)
            3'd0: begin
                n_rr = 8'd255;   n_rg = a_up255; n_rb = 8'd0;
            end
            3'd1: begin
                n_rr = a_dn255;  n_rg = 8'd255;  n_rb = 8'd0;
            end
            3'd2: begin
                n_rr = 8'd0;     n_rg = 8'd255;  n_rb = a_up255;
            end
            3'd3: begin
                n_rr = 8'd0;     n_rg = a_dn255; n_rb = 8'd255;
            end
            3'd4: begin
                n_rr = a_up128;  n_rg = 8'd0;    n_rb = 8'd255;
            end
            default: begin
                n_rr = 8'd128 + a_up127; n_rg = 8'd0; n_rb = a_dn255;
            end
        endcase
    end

    logic        r2_vld;
    logic        r2_ok;
    logic [16:0] r2_w;
    logic [7:0]  r2_rr;
    logic [7:0]  r2_rg;
    logic [7:0]  r2_rb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_ok <= r1_ok;
        r2_w  <= WAVE[r1_k];
        r2_rr <= n_rr;
        r2_rg <= n_rg;
        r2_rb <= n_rb;
    end

    // stage 3: breathing scale and output select
    logic [24:0] br;
    logic [24:0] bg;
    logic [24:0] bb;
    assign br = {17'b0, i_cfg.breath_red}   * {8'b0, r2_w};
    assign bg = {17'b0, i_cfg.breath_green} * {8'b0, r2_w};
    assign bb = {17'b0, i_cfg.breath_blue}  * {8'b0, r2_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r2_vld;
        end
        o_index_valid <= r2_ok;
        if (!r2_ok) begin
            o_red_level   <= 8'd0;
            o_green_level <= 8'd0;
            o_blue_level  <= 8'd0;
        end else if (i_cfg.effect_mode) begin
            o_red_level   <= r2_rr;
            o_green_level <= r2_rg;
            o_blue_level  <= r2_rb;
        end else begin
            o_red_level   <= br[23:16];
            o_green_level <= bg[23:16];
            o_blue_level  <= bb[23:16];
        end
    end
endmodule

FILE: rtl/core/led_effect_color_generator_top.sv
// top level of the led effect color generator: config registers, front end,
// queue and back end; uses lecg_pkg, lecg_front, lecg_queue, lecg_back
//
// usage: a request (elapsed_ms, led_index) is taken on a rising edge with
// start high and busy low. one color result per request comes back on
// o_red_level, o_green_level, o_blue_level and o_index_valid, marked by
// o_valid for exactly one cycle; results keep request order.
// the request passes through the bit-per-stage divider pipeline that forms
// elapsed mod period (32 stages) and then the phase fraction (PHASE_BITS
// stages), then the queue and three color stages. a new request can be
// taken every cycle while busy is low.
// configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data with
// no wait; write only while no request is in flight. unknown indexes are
// ignored.
// reset (i_rst_n low, synchronous) loads the register defaults and empties
// the pipeline. the receiver cannot stall; busy only rises if the queue
// were full, which the back end, draining every cycle, never lets happen.
module led_effect_color_generator_top #(
    parameter int LED_CAP          = 1024,
    parameter int PHASE_BITS       = 16,
    parameter int WAVE_TABLE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [31:0]                    i_elapsed_ms,
    input  logic [9:0]                     i_led_index,
    input  logic                           i_cfg_we,
    input  logic [lecg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_data,
    output logic                           o_valid,
    output logic [7:0]                     o_red_level,
    output logic [7:0]                     o_green_level,
    output logic [7:0]                     o_blue_level,
    output logic                           o_index_valid
);
    localparam int IW = 2 * PHASE_BITS + 1;

    lecg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.effect_mode  <= 1'b0;
            r_cfg.period       <= lecg_pkg::PERIOD_RESET;
            r_cfg.led_count    <= lecg_pkg::COUNT_RESET;
            r_cfg.breath_red   <= 8'd0;
            r_cfg.breath_green <= 8'd0;
            r_cfg.breath_blue  <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lecg_pkg::CFG_EFFECT_MODE:  r_cfg.effect_mode  <= i_cfg_data[0];
                lecg_pkg::CFG_PERIOD:       r_cfg.period       <= i_cfg_data;
                lecg_pkg::CFG_LED_COUNT:    r_cfg.led_count    <= i_cfg_data[10:0];
                lecg_pkg::CFG_BREATH_RED:   r_cfg.breath_red   <= i_cfg_data[7:0];
                lecg_pkg::CFG_BREATH_GREEN: r_cfg.breath_green <= i_cfg_data[7:0];
                lecg_pkg::CFG_BREATH_BLUE:  r_cfg.breath_blue  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic          push;
    logic [IW-1:0] f_item;
    logic          q_empty;
    logic          q_full;
    logic [IW-1:0] q_data;

    lecg_front #(
        .PHASE_BITS (PHASE_BITS),
        .LED_CAP    (LED_CAP)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_take       (start && !busy),
        .i_elapsed_ms (i_elapsed_ms),
        .i_led_index  (i_led_index),
        .o_push       (push),
        .o_item       (f_item)
    );

    lecg_queue #(
        .W (IW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_item),
        .i_pop   (1'b1),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    assign busy = q_full;

    lecg_back #(
        .PHASE_BITS       (PHASE_BITS),
        .WAVE_TABLE_DEPTH (WAVE_TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_vld         (!q_empty),
        .i_item        (q_data),
        .o_valid       (o_valid),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level),
        .o_index_valid (o_index_valid)
    );
endmodule
